/* hw/rtl/radix_converter_unit_assert.svh */
// Assertion macros for the RTL checks in rcu_back.
`ifndef RADIX_CONVERTER_UNIT_ASSERT_SVH
`define RADIX_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define RCU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("radix_converter_unit: check failed");
`define RCU_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("radix_converter_unit: check failed");
`else
`define RCU_ASSERT(lbl, clk, rst, prop)
`define RCU_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/rcu_pkg.sv */
package rcu_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int STORE_DEPTH = 32;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
   localparam int DIGIT_W     = 6;
   localparam int BASE_W      = 6;
   localparam int CHAR_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;

   localparam logic [BASE_W-1:0] BASE_MIN          = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX          = 6'd36;
   localparam logic [BASE_W-1:0] SOURCE_BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] TARGET_BASE_RESET = 6'd2;

   localparam logic [DIGIT_W-1:0] NON_DIGIT      = 6'd36;
   localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_0  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_9  = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_UA = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_UZ = 8'd90;
   localparam logic [CHAR_W-1:0] CHAR_LA = 8'd97;
   localparam logic [CHAR_W-1:0] CHAR_LZ = 8'd122;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_BASE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_BASE = 1'b1;

   typedef struct packed {
      logic [CHAR_W-1:0] in_char;
      logic              in_last;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   out_char;
      logic                out_last;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               bad;
      logic               last;
   } entry_type;

   function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      r = b;
      if (b < BASE_MIN) r = BASE_MIN;
      if (b > BASE_MAX) r = BASE_MAX;
      return r;
   endfunction

   function automatic logic [DIGIT_W-1:0] decode_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] diff;
      logic [DIGIT_W-1:0] d;
      d = NON_DIGIT;
      diff = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         diff = c - CHAR_0;
         d = diff[DIGIT_W-1:0];
      end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
         diff = c - CHAR_UA;
         d = diff[DIGIT_W-1:0] + DECIMAL_DIGITS;
      end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
         diff = c - CHAR_LA;
         d = diff[DIGIT_W-1:0] + DECIMAL_DIGITS;
      end
      return d;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] r;
      if (d < DECIMAL_DIGITS) begin
         r = CHAR_0 + {2'b00, d};
      end else begin
         r = CHAR_UA + {2'b00, d} - {2'b00, DECIMAL_DIGITS};
      end
      return r;
   endfunction

endpackage

/* hw/rtl/rcu_ram.sv */
module rcu_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/rcu_front.sv */
module rcu_front (
   input  logic                          start,
   input  rcu_pkg::req_type              req_data,
   input  logic [rcu_pkg::BASE_W-1:0]    source_base,
   input  logic                          queue_full,
   output logic                          busy,
   output logic                          push,
   output rcu_pkg::entry_type            entry
);
   import rcu_pkg::*;

   logic [DIGIT_W-1:0] digit;
   logic [BASE_W-1:0]  base;

   always_comb begin
      digit       = decode_char(req_data.in_char);
      base        = clamp_base(source_base);
      entry.digit = digit;
      entry.bad   = (digit >= base);
      entry.last  = req_data.in_last;
   end

   assign busy = queue_full;
   assign push = start & ~queue_full;

endmodule

/* hw/rtl/rcu_queue.sv */
module rcu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rcu_pkg::entry_type push_entry,
   input  logic               pop,
   output rcu_pkg::entry_type pop_entry,
   output logic               full,
   output logic               empty
);
   import rcu_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hw/rtl/rcu_back.sv */
`include "radix_converter_unit_assert.svh"

module rcu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rcu_pkg::BASE_W-1:0] source_base,
   input  logic [rcu_pkg::BASE_W-1:0] target_base,
   input  rcu_pkg::entry_type         entry,
   input  logic                       queue_empty,
   output logic                       pop,
   output logic                       rsp_valid,
   output rcu_pkg::rsp_type           rsp_data
);
   import rcu_pkg::*;

   localparam int PROD_W = VALUE_BITS + BASE_W;
   localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(VALUE_BITS - 1);
   localparam logic [COUNT_W-1:0]   COUNT_FULL = COUNT_W'(STORE_DEPTH);

   typedef enum logic [1:0] {
      S_ACCUM,
      S_DIV,
      S_RD,
      S_OUT
   } state_type;

   state_type              state_ff;
   logic [VALUE_BITS-1:0]  acc_ff;
   logic [STATUS_W-1:0]    err_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [VALUE_BITS-1:0]  work_ff;
   logic [BASE_W-1:0]      rem_ff;
   logic [BIT_CNT_W-1:0]   bit_ff;
   logic [STORE_AW-1:0]    rd_idx_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   logic [BASE_W-1:0]      src_base, tgt_base;
   logic [PROD_W-1:0]      prod;
   logic [PROD_W:0]        sum;
   logic                   ovf;
   logic [VALUE_BITS-1:0]  acc_in;
   logic [STATUS_W-1:0]    err_in;
   logic [BASE_W:0]        trial, diff;
   logic                   q_bit;
   logic [BASE_W-1:0]      rem_in;
   logic [VALUE_BITS-1:0]  work_in;
   logic                   div_done, store_ok;
   logic [DIGIT_W-1:0]     ram_rdata;

   assign src_base = clamp_base(source_base);
   assign tgt_base = clamp_base(target_base);
   assign pop      = (state_ff == S_ACCUM) & ~queue_empty;

   always_comb begin
      prod   = {{BASE_W{1'b0}}, acc_ff} * {{VALUE_BITS{1'b0}}, src_base};
      sum    = {1'b0, prod} + (PROD_W + 1)'(entry.digit);
      ovf    = |sum[PROD_W:VALUE_BITS];
      acc_in = acc_ff;
      err_in = err_ff;
      if (entry.bad) begin
         if (err_ff == STATUS_OK) err_in = STATUS_BAD_CHAR;
      end else begin
         acc_in = sum[VALUE_BITS-1:0];
         if (ovf && err_ff == STATUS_OK) err_in = STATUS_OVERFLOW;
      end
   end

   always_comb begin
      trial    = {rem_ff, work_ff[VALUE_BITS-1]};
      diff     = trial - {1'b0, tgt_base};
      q_bit    = (trial >= {1'b0, tgt_base});
      rem_in   = q_bit ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
      work_in  = {work_ff[VALUE_BITS-2:0], q_bit};
      div_done = (state_ff == S_DIV) && (bit_ff == BIT_LAST);
      store_ok = (count_ff < COUNT_FULL);
   end

   rcu_ram #(
      .WIDTH(DIGIT_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .we   (div_done & store_ok),
      .waddr(count_ff[STORE_AW-1:0]),
      .wdata(rem_in),
      .raddr(rd_idx_ff),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACCUM;
         acc_ff       <= '0;
         err_ff       <= STATUS_OK;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_ACCUM: begin
               if (!queue_empty) begin
                  err_ff <= err_in;
                  if (entry.last) begin
                     work_ff  <= acc_in;
                     acc_ff   <= '0;
                     rem_ff   <= '0;
                     bit_ff   <= '0;
                     count_ff <= '0;
                     state_ff <= S_DIV;
                  end else begin
                     acc_ff <= acc_in;
                  end
               end
            end
            S_DIV: begin
               work_ff <= work_in;
               rem_ff  <= rem_in;
               bit_ff  <= bit_ff + 1'b1;
               if (div_done) begin
                  if (store_ok) begin
                     count_ff <= count_ff + 1'b1;
                  end else if (err_ff == STATUS_OK) begin
                     err_ff <= STATUS_OVERFLOW;
                  end
                  if (work_in == '0) begin
                     rd_idx_ff <= store_ok ? count_ff[STORE_AW-1:0] : '1;
                     state_ff  <= S_RD;
                  end else begin
                     rem_ff <= '0;
                     bit_ff <= '0;
                  end
               end
            end
            S_RD: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_valid_ff         <= 1'b1;
               rsp_data_ff.out_char <= digit_to_char(ram_rdata);
               rsp_data_ff.out_last <= (rd_idx_ff == '0);
               rsp_data_ff.status   <= err_ff;
               if (rd_idx_ff == '0) begin
                  err_ff   <= STATUS_OK;
                  count_ff <= '0;
                  state_ff <= S_ACCUM;
               end else begin
                  rd_idx_ff <= rd_idx_ff - 1'b1;
                  state_ff  <= S_RD;
               end
            end
            default: begin
               state_ff <= S_ACCUM;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RCU_ASSERT(a_count_bound, clock, reset, count_ff <= COUNT_FULL)
   `RCU_ASSERT_IMPLY(a_read_in_range, clock, reset, state_ff == S_RD,
      {{(COUNT_W - STORE_AW){1'b0}}, rd_idx_ff} < count_ff)
   `RCU_ASSERT_IMPLY(a_rsp_digit, clock, reset, rsp_valid_ff,
      (rsp_data_ff.out_char >= CHAR_0 && rsp_data_ff.out_char <= CHAR_9) ||
      (rsp_data_ff.out_char >= CHAR_UA && rsp_data_ff.out_char <= CHAR_UZ))
   `RCU_ASSERT_IMPLY(a_rsp_from_out, clock, reset, rsp_valid_ff, $past(state_ff == S_OUT))

endmodule

/* hw/rtl/radix_converter_unit.sv */
// Radix converter: turns a number written in ASCII digits of one base into
// the ASCII digits of another base.
// Input: characters arrive on req_data with start; a transaction is taken at
// a clock edge where start is high and busy is low. in_last marks the final
// character. Characters 0-9, A-Z, a-z are digits; anything else, or a digit
// not below the source base, is skipped and flags status 1.
// Output: each digit leaves on rsp_data for one cycle with rsp_valid high,
// most significant first, upper-case letters, out_last on the final digit.
// There is no back-pressure on the output; the receiver must take every
// digit. Status (1 bad character, 2 overflow) is the same on all digits.
// Configuration: csr_we writes csr_wdata to source base (index 0, reset 10)
// or target base (index 1, reset 2); values outside 2..36 are clamped.
// Timing: a two-entry queue sits between the character decoder and the
// arithmetic engine; while accumulating, the engine folds in one character
// per cycle, so busy stays low while characters stream. After the last
// character, each output digit is produced by the bit-serial divider, then
// every digit is read back from the digit store and presented in turn.
// busy rises when the queue fills during conversion.
// Reset (synchronous, active high) clears the value, status and queue.
module radix_converter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  rcu_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output rcu_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [rcu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcu_pkg::BASE_W-1:0]      csr_wdata
);
   import rcu_pkg::*;

   logic [BASE_W-1:0] src_base_ff;
   logic [BASE_W-1:0] tgt_base_ff;
   logic              queue_full, queue_empty;
   logic              push, pop;
   entry_type         push_entry, pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_base_ff <= SOURCE_BASE_RESET;
         tgt_base_ff <= TARGET_BASE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SOURCE_BASE: src_base_ff <= csr_wdata;
            CSR_TARGET_BASE: tgt_base_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rcu_front u_front (
      .start      (start),
      .req_data   (req_data),
      .source_base(src_base_ff),
      .queue_full (queue_full),
      .busy       (busy),
      .push       (push),
      .entry      (push_entry)
   );

   rcu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .pop_entry (pop_entry),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   rcu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .source_base(src_base_ff),
      .target_base(tgt_base_ff),
      .entry      (pop_entry),
      .queue_empty(queue_empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
